// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Assertions use the clock clk and the active-low reset arst_n of the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising clock edge, idle while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must hold whenever a stage holds a valid item.
`define ASSERT_VLD(lbl, vld, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (vld) |-> (cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_VLD(lbl, vld, cond, msg)

`endif

`endif

// ===== hw/rtl/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

	// Hue reduction constants
	localparam logic [8:0]  HUE_TURN   = 9'd360;
	localparam logic [5:0]  HUE_SECTOR = 6'd60;
	// floor(2^16 / 360): quotient estimate is low by at most one
	localparam logic [7:0]  HUE_RECIP  = 8'd182;
	localparam logic [7:0]  LEVEL_MAX  = 8'd255;
	// Largest fraction: 59 * 255 / 60
	localparam logic [7:0]  FRAC_MAX   = 8'd250;

	// Hue sectors, 60 degrees each
	localparam logic [2:0] SECT_RY = 3'd0;
	localparam logic [2:0] SECT_YG = 3'd1;
	localparam logic [2:0] SECT_GC = 3'd2;
	localparam logic [2:0] SECT_CB = 3'd3;
	localparam logic [2:0] SECT_BM = 3'd4;
	localparam logic [2:0] SECT_MR = 3'd5;

	// Hue split into sector and fraction, with the levels riding along
	typedef struct packed {
		logic [2:0] sector;
		logic [7:0] frac;
		logic [7:0] sat;
		logic [7:0] val;
	} hsv_frac_t;

	// Truncating x / 255 for x <= 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

endpackage

// ===== hw/rtl/hsvrgb_hue.sv =====
module hsvrgb_hue (
	input  logic                   clk,
	input  logic                   en,
	input  logic [15:0]            hue,
	input  logic [7:0]             saturation,
	input  logic [7:0]             brightness,
	output hsvrgb_pkg::hsv_frac_t  frac_s3
);
	import hsvrgb_pkg::*;

	logic [7:0]  quot_s1;
	logic [15:0] hue_s1;
	logic [7:0]  sat_s1, val_s1;

	logic [8:0]  hue_s2;
	logic [7:0]  sat_s2, val_s2;

	logic [23:0] recip_prod;
	logic [15:0] quot_x360;
	logic [15:0] hue_rem;
	logic [8:0]  hue_mod;

	logic [2:0]  sector;
	logic [8:0]  sector_base;
	logic [5:0]  sect_rem;
	logic [9:0]  frac_x4;

	// Stage 1: quotient estimate of hue / 360
	assign recip_prod = hue * HUE_RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s1 <= recip_prod[23:16];
			hue_s1  <= hue;
			sat_s1  <= saturation;
			val_s1  <= brightness;
		end
	end

	// Stage 2: remainder, one correction step
	assign quot_x360 = 16'(quot_s1 * HUE_TURN);
	assign hue_rem   = hue_s1 - quot_x360;
	assign hue_mod   = (hue_rem >= 16'(HUE_TURN)) ? 9'(hue_rem - 16'(HUE_TURN))
						: hue_rem[8:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s2 <= hue_mod;
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
	end

	// Stage 3: sector by compare chain, fraction = rem * 255 / 60 = rem * 17 / 4
	always_comb begin
		if (hue_s2 >= 9'(5 * HUE_SECTOR)) begin
			sector = SECT_MR;
		end else if (hue_s2 >= 9'(4 * HUE_SECTOR)) begin
			sector = SECT_BM;
		end else if (hue_s2 >= 9'(3 * HUE_SECTOR)) begin
			sector = SECT_CB;
		end else if (hue_s2 >= 9'(2 * HUE_SECTOR)) begin
			sector = SECT_GC;
		end else if (hue_s2 >= 9'(HUE_SECTOR)) begin
			sector = SECT_YG;
		end else begin
			sector = SECT_RY;
		end
	end

	assign sector_base = 9'(sector * HUE_SECTOR);
	assign sect_rem    = 6'(hue_s2 - sector_base);
	assign frac_x4     = {4'd0, sect_rem} * 10'd17;

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s3.sector <= sector;
			frac_s3.frac   <= frac_x4[9:2];
			frac_s3.sat    <= sat_s2;
			frac_s3.val    <= val_s2;
		end
	end

endmodule

// ===== hw/rtl/hsvrgb_mix.sv =====
module hsvrgb_mix (
	input  logic                   clk,
	input  logic                   en,
	input  hsvrgb_pkg::hsv_frac_t  frac_s3,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);
	import hsvrgb_pkg::*;

	logic [15:0] prod_p_s4, prod_q_s4, prod_t_s4;
	logic [2:0]  sector_s4, sector_s5, sector_s6;
	logic [7:0]  val_s4, val_s5, val_s6;

	logic [7:0]  p_s5, kq_s5, kt_s5;
	logic [7:0]  p_s6;
	logic [15:0] prod_q_s6, prod_t_s6;

	logic [7:0]  q_lvl, t_lvl;
	logic [7:0]  r_nxt, g_nxt, b_nxt;

	// Stage 4: v * (255 - s), s * f, s * (255 - f)
	always_ff @(posedge clk) begin
		if (en) begin
			prod_p_s4 <= frac_s3.val * (LEVEL_MAX - frac_s3.sat);
			prod_q_s4 <= frac_s3.sat * frac_s3.frac;
			prod_t_s4 <= frac_s3.sat * (LEVEL_MAX - frac_s3.frac);
			sector_s4 <= frac_s3.sector;
			val_s4    <= frac_s3.val;
		end
	end

	// Stage 5: divide by 255
	always_ff @(posedge clk) begin
		if (en) begin
			p_s5      <= div255(prod_p_s4);
			kq_s5     <= div255(prod_q_s4);
			kt_s5     <= div255(prod_t_s4);
			sector_s5 <= sector_s4;
			val_s5    <= val_s4;
		end
	end

	// Stage 6: v * (255 - k) for q and t
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q_s6 <= val_s5 * (LEVEL_MAX - kq_s5);
			prod_t_s6 <= val_s5 * (LEVEL_MAX - kt_s5);
			p_s6      <= p_s5;
			sector_s6 <= sector_s5;
			val_s6    <= val_s5;
		end
	end

	// Stage 7: final divide and channel permutation; zero saturation
	// gives p = q = t = v, so grey needs no path of its own
	assign q_lvl = div255(prod_q_s6);
	assign t_lvl = div255(prod_t_s6);

	always_comb begin
		case (sector_s6)
			SECT_RY: begin r_nxt = val_s6; g_nxt = t_lvl;  b_nxt = p_s6;   end
			SECT_YG: begin r_nxt = q_lvl;  g_nxt = val_s6; b_nxt = p_s6;   end
			SECT_GC: begin r_nxt = p_s6;   g_nxt = val_s6; b_nxt = t_lvl;  end
			SECT_CB: begin r_nxt = p_s6;   g_nxt = q_lvl;  b_nxt = val_s6; end
			SECT_BM: begin r_nxt = t_lvl;  g_nxt = p_s6;   b_nxt = val_s6; end
			default: begin r_nxt = val_s6; g_nxt = p_s6;   b_nxt = q_lvl;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red   <= r_nxt;
			green <= g_nxt;
			blue  <= b_nxt;
		end
	end

endmodule

// ===== hw/rtl/hsv_to_rgb_integer.sv =====
// HSV to RGB converter, 8-bit integer levels.
// Input channel: in_valid / in_ready carry hue (degrees, any 16-bit value,
// reduced modulo 360), saturation and brightness. Output channel:
// out_valid / out_ready carry red, green and blue.
// Throughput: one color per cycle unless stalled; the seven register stages (two
// for hue reduction, sector split, multiply, divide-by-255, multiply, final divide
// with channel select) each take a new item every cycle that the pipeline advances.
// Stalls: when out_ready is low with a result waiting, the whole pipeline
// holds, empty stages included, and in_ready drops in the same cycle.
// in_ready = !out_valid || out_ready.
// Reset: arst_n clears all stage valid bits at once; data registers are
// not reset. The block keeps no state between colors.
module hsv_to_rgb_integer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import hsvrgb_pkg::*;

	`include "assert_macros.svh"

	logic      en;
	logic      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	hsv_frac_t frac_s3;

	// Pipeline advances whenever the output slot is free or being taken
	assign en        = !vld_s7 || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s7;

	// Valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	hsvrgb_hue u_hue (
		.clk        (clk),
		.en         (en),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.frac_s3    (frac_s3)
	);

	hsvrgb_mix u_mix (
		.clk     (clk),
		.en      (en),
		.frac_s3 (frac_s3),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

	// A stalled result blocks new transfers
	`ASSERT_CLK(a_stall_blocks_in, (out_valid && !out_ready) |-> !in_ready, "in_ready high during output stall")
	// An empty output slot always takes input
	`ASSERT_CLK(a_empty_takes_in, !out_valid |-> in_ready, "in_ready low with empty output")
	// Hue reduction lands in a real sector
	`ASSERT_VLD(a_sector_range, vld_s3, frac_s3.sector <= SECT_MR, "sector out of range")
	// Fraction bounded by 59 * 255 / 60
	`ASSERT_VLD(a_frac_range, vld_s3, frac_s3.frac <= FRAC_MAX, "fraction out of range")

endmodule
